>>> design/kmp_pkg.sv
// Shared constants, opcode and sequencer types for the KMP string matcher.
package kmp_pkg;

  localparam int MAX_PATTERN   = 64;
  localparam int POSITION_BITS = 20;

  // Length counters hold 0..MAX_PATTERN; store index covers 0..MAX_PATTERN-1.
  localparam int LEN_W     = $clog2(MAX_PATTERN + 1);
  localparam int STORE_AW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int FAIL_DEPTH = MAX_PATTERN + 1;

  // Fixed field widths of the stream payloads.
  localparam int CHAR_W    = 8;
  localparam int OP_W      = 2;
  localparam int OUT_POS_W = 20;
  localparam int POS_EXT_W = (POSITION_BITS > OUT_POS_W) ? POSITION_BITS : OUT_POS_W;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 24;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2
  } op_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_CMP   = 6'b000100,
    S_MREAD = 6'b001000,
    S_MWRAP = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

endpackage

>>> design/kmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/kmp_string_matcher.sv
// Top level of the streaming Knuth-Morris-Pratt string matcher.
//
//  channel  dir  fields (tdata low bit up)                 transfer meaning
//  s_axis   in   opcode[1:0], char_value[9:2]; tlast=eot   one command or byte
//  m_axis   out  found[0], last_match_start[20:1]          one end-of-text result
//
// Clear, opcode 3, an ignored append and the first pattern byte finish in the idle
// state. Any other append and any text byte pass S_READ then S_CMP, repeating both
// for each failure-table fallback, and a full match adds S_MREAD and S_MWRAP;
// the read step is set by the registered read of the pattern and failure
// RAMs feeding one compare. A text byte with an empty pattern stays in idle.
// An end-of-text byte adds the emit state, held while the output register is held.
// Reset (rst, synchronous) clears the architectural lengths, positions and flags; the RAMs
// are not cleared and need no clearing pass. s_axis_tready is high only while
// the sequencer is idle. An end-of-text result waits for a free output register.
module kmp_string_matcher
  import kmp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // opcode[1:0], char_value[9:2], zero pad
  input  logic                 s_axis_tlast,   // end_of_text
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata    // found[0], last_match_start[20:1], zero pad
);

  state_t state;

  // Architectural state.
  logic [LEN_W-1:0]         plen;       // pattern length
  logic [LEN_W-1:0]         bpl;        // running border of the pattern
  logic [LEN_W-1:0]         matched;    // matched length carried between text bytes
  logic [POSITION_BITS-1:0] pos;        // saturating text position
  logic [POSITION_BITS-1:0] last_start;
  logic                     seen;

  // Working registers of the sequencer.
  logic [LEN_W-1:0]  k;
  logic [CHAR_W-1:0] ch;
  logic              eot;
  logic              build;

  // Output register.
  logic                 out_found;
  logic [OUT_POS_W-1:0] out_pos;

  // Input decode.
  op_t               in_op;
  logic [CHAR_W-1:0] in_char;
  logic              in_xfer;

  assign in_op   = op_t'(s_axis_tdata[OP_W-1:0]);
  assign in_char = s_axis_tdata[OP_W+CHAR_W-1:OP_W];
  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // RAM ports.
  logic                store_we;
  logic [STORE_AW-1:0] store_waddr;
  logic [CHAR_W-1:0]   store_rd;
  logic                fail_we;
  logic [LEN_W-1:0]    fail_waddr;
  logic [LEN_W-1:0]    fail_wdata;
  logic [LEN_W-1:0]    fail_rd;

  // Shared compare and its step result.
  logic             hit;
  logic [LEN_W-1:0] k_adv;
  logic             out_free;

  assign hit      = (store_rd == ch);
  assign k_adv    = hit ? (k + LEN_W'(1)) : k;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Match start: pos + 1 - len, clamped to 1.
  logic [POSITION_BITS:0] pos_p1;
  logic [POSITION_BITS:0] len_ext;
  logic [POSITION_BITS:0] start_diff;

  assign pos_p1     = {1'b0, pos} + (POSITION_BITS+1)'(1);
  assign len_ext    = (POSITION_BITS+1)'(plen);
  assign start_diff = pos_p1 - len_ext;

  logic [POS_EXT_W-1:0] last_ext;
  assign last_ext = POS_EXT_W'(last_start);

  assign store_we    = in_xfer && (in_op == OP_APPEND) && (plen < LEN_W'(MAX_PATTERN));
  assign store_waddr = plen[STORE_AW-1:0];

  always_comb begin
    fail_we    = 1'b0;
    fail_waddr = plen + LEN_W'(1);
    fail_wdata = '0;
    if (store_we && (plen == '0)) begin
      fail_we = 1'b1;
    end else if ((state == S_CMP) && build && !(k != '0 && !hit)) begin
      // Close the table build: entry len+1 takes the extended border.
      fail_we    = 1'b1;
      fail_wdata = k_adv;
    end
  end

  kmp_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(MAX_PATTERN)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(store_waddr),
    .wdata(in_char),
    .raddr(k[STORE_AW-1:0]),
    .rdata(store_rd)
  );

  kmp_ram #(
    .WIDTH(LEN_W),
    .DEPTH(FAIL_DEPTH)
  ) u_fail (
    .clk  (clk),
    .we   (fail_we),
    .waddr(fail_waddr),
    .wdata(fail_wdata),
    .raddr(k),
    .rdata(fail_rd)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      plen       <= '0;
      bpl        <= '0;
      matched    <= '0;
      pos        <= '0;
      last_start <= '0;
      seen       <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            ch    <= in_char;
            eot   <= s_axis_tlast;
            build <= (in_op == OP_APPEND);
            case (in_op)
              OP_CLEAR: begin
                plen       <= '0;
                bpl        <= '0;
                matched    <= '0;
                pos        <= '0;
                last_start <= '0;
                seen       <= 1'b0;
              end
              OP_APPEND: begin
                if (store_we) begin
                  if (plen == '0) begin
                    bpl  <= '0;
                    plen <= LEN_W'(1);
                  end else begin
                    // Walk the borders starting from the running one.
                    k     <= bpl;
                    state <= S_READ;
                  end
                end
              end
              OP_TEXT: begin
                if (pos != '1) begin
                  pos <= pos + POSITION_BITS'(1);
                end
                if (plen == '0) begin
                  if (s_axis_tlast) begin
                    state <= S_EMIT;
                  end
                end else begin
                  k     <= (matched >= plen) ? '0 : matched;
                  state <= S_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (k != '0 && !hit) begin
            // Fall back along the failure chain.
            k     <= fail_rd;
            state <= S_READ;
          end else if (build) begin
            bpl   <= k_adv;
            plen  <= plen + LEN_W'(1);
            state <= S_IDLE;
          end else if (k_adv == plen) begin
            seen       <= 1'b1;
            last_start <= (pos_p1 > len_ext) ? start_diff[POSITION_BITS-1:0]
                                             : POSITION_BITS'(1);
            k          <= plen;
            state      <= S_MREAD;
          end else begin
            matched <= k_adv;
            state   <= eot ? S_EMIT : S_IDLE;
          end
        end
        S_MREAD: begin
          state <= S_MWRAP;
        end
        S_MWRAP: begin
          // Continue from the border of the full pattern for overlaps.
          matched <= fail_rd;
          state   <= eot ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            matched    <= '0;
            pos        <= '0;
            last_start <= '0;
            seen       <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load on emit, drop on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      out_found <= seen;
      out_pos   <= seen ? last_ext[OUT_POS_W-1:0] : '0;
    end
  end

  assign m_axis_tdata = {(M_TDATA_W-OUT_POS_W-1)'(0), out_pos, out_found};

endmodule
